FILE: hw/rtl/cartesian_to_radar_measurement_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the cartesian to radar measurement block
// Short forms for clocked, reset-qualified concurrent assertions.
// ---------------------------------------------------------------------------
`ifndef CARTESIAN_TO_RADAR_MEASUREMENT_MACROS_SVH
`define CARTESIAN_TO_RADAR_MEASUREMENT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define C2R_ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define C2R_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: hw/rtl/c2r_pkg.sv
// ---------------------------------------------------------------------------
// Cartesian to radar measurement package
// Shared constants, angle table functions and cell data types.
// ---------------------------------------------------------------------------
package c2r_pkg;

  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 24;
  localparam int MAX_STEPS        = 32;
  localparam int ANG_FRAC         = 60;
  localparam int NORM_TOP         = 40;
  localparam int NORM_W           = NORM_TOP + 1;
  localparam int NORM_STAGES      = 6;
  localparam int CW               = 46;
  localparam int ZW               = 64;
  localparam int LIMIT_W          = 17;
  localparam int SQRT_STEPS       = 32;
  localparam int DIV_STEPS        = 32;
  localparam int IN_W             = 128;
  localparam int OUT_W            = 88;
  localparam int BEAR_W           = 19;

  localparam logic [1:0] BASE_NONE = 2'd0;
  localparam logic [1:0] BASE_POS  = 2'd1;
  localparam logic [1:0] BASE_NEG  = 2'd2;

  // Restoring division, used only to build constants.
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], a[i]};
      if (r >= {1'b0, b}) begin
        r = r - {1'b0, b};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(1/n) with ANG_FRAC fraction bits by its power series.
  function automatic logic [63:0] atan_recip(input logic [63:0] n);
    logic [63:0] p;
    logic [63:0] nn;
    logic [63:0] sum;
    logic [63:0] k;
    logic [63:0] t;
    p   = udiv64(64'd1 << ANG_FRAC, n);
    nn  = n * n;
    sum = '0;
    k   = '0;
    while (p != 64'd0) begin
      t = udiv64(p, (k << 1) + 64'd1);
      if (!k[0]) begin
        sum = sum + t;
      end else begin
        sum = sum - t;
      end
      p = udiv64(p, nn);
      k = k + 64'd1;
    end
    return sum;
  endfunction

  function automatic logic [63:0] atan_step(input int i);
    if (i == 0) begin
      return atan_recip(64'd2) + atan_recip(64'd3);
    end
    return atan_recip(64'd1 << i);
  endfunction

  localparam logic [63:0] QUARTER = atan_recip(64'd2) + atan_recip(64'd3);
  localparam logic [63:0] PI_ANG  = QUARTER << 2;

  typedef struct packed {
    logic [63:0] v;
    logic [34:0] rem;
    logic [31:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [31:0] quo;
    logic [31:0] dvs;
    logic        neg;
    logic        nz;
    logic        sat;
  } div_t;

  typedef struct packed {
    logic [NORM_W-1:0] ax;
    logic [NORM_W-1:0] ay;
    logic              yneg;
    logic [1:0]        bsel;
    logic              zero;
  } norm_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [1:0]           bsel;
    logic                 zero;
  } cord_t;

endpackage

FILE: hw/rtl/c2r_sqrt_cell.sv
// ---------------------------------------------------------------------------
// Square root cell
// Resolves one root bit per cycle from two radicand bits, while enabled.
// ---------------------------------------------------------------------------
module c2r_sqrt_cell (
  input  logic            clk_i,
  input  logic            en_i,
  input  c2r_pkg::sqrt_t  d_i,
  output c2r_pkg::sqrt_t  q_o
);
  import c2r_pkg::*;

  sqrt_t       cell_d;
  sqrt_t       cell_q;
  logic [34:0] rem_sh;
  logic [34:0] trial;

  always_comb begin
    rem_sh   = {d_i.rem[32:0], d_i.v[63:62]};
    trial    = {1'b0, d_i.root, 2'b01};
    cell_d.v = {d_i.v[61:0], 2'b00};
    if (rem_sh >= trial) begin
      cell_d.rem  = rem_sh - trial;
      cell_d.root = {d_i.root[30:0], 1'b1};
    end else begin
      cell_d.rem  = rem_sh;
      cell_d.root = {d_i.root[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign q_o = cell_q;

endmodule

FILE: hw/rtl/c2r_div_cell.sv
// ---------------------------------------------------------------------------
// Division cell
// Resolves one quotient bit of the range rate per cycle while enabled.
// ---------------------------------------------------------------------------
module c2r_div_cell #(
  parameter int BIT = 0
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  c2r_pkg::div_t  d_i,
  output c2r_pkg::div_t  q_o
);
  import c2r_pkg::*;

  div_t        cell_d;
  div_t        cell_q;
  logic [63:0] dsh;

  always_comb begin
    dsh    = 64'(d_i.dvs) << BIT;
    cell_d = d_i;
    if (d_i.rem >= dsh) begin
      cell_d.rem      = d_i.rem - dsh;
      cell_d.quo[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign q_o = cell_q;

endmodule

FILE: hw/rtl/c2r_norm_cell.sv
// ---------------------------------------------------------------------------
// Normalization cell
// Shifts both magnitudes left by a fixed amount when the larger still fits.
// ---------------------------------------------------------------------------
module c2r_norm_cell #(
  parameter int SHIFT = 1
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  c2r_pkg::norm_t  d_i,
  output c2r_pkg::norm_t  q_o
);
  import c2r_pkg::*;

  norm_t             cell_d;
  norm_t             cell_q;
  logic [NORM_W-1:0] mx;

  always_comb begin
    mx     = (d_i.ax > d_i.ay) ? d_i.ax : d_i.ay;
    cell_d = d_i;
    if ((mx >> (NORM_W - SHIFT)) == '0) begin
      cell_d.ax = d_i.ax << SHIFT;
      cell_d.ay = d_i.ay << SHIFT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign q_o = cell_q;

endmodule

FILE: hw/rtl/c2r_cordic_cell.sv
// ---------------------------------------------------------------------------
// CORDIC vectoring cell
// One micro-rotation toward the x axis with its angle accumulation, skipped when y is zero.
// ---------------------------------------------------------------------------
module c2r_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  c2r_pkg::cord_t  d_i,
  output c2r_pkg::cord_t  q_o
);
  import c2r_pkg::*;

  localparam logic signed [ZW-1:0] ANG = $signed(atan_step(STEP));

  cord_t                cell_d;
  cord_t                cell_q;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;

  always_comb begin
    xs     = d_i.x;
    ys     = d_i.y;
    dx     = ys >>> STEP;
    dy     = xs >>> STEP;
    cell_d = d_i;
    if (ys[CW-1]) begin
      cell_d.x = xs - dx;
      cell_d.y = ys + dy;
      cell_d.z = d_i.z - ANG;
    end else if (ys != '0) begin
      cell_d.x = xs + dx;
      cell_d.y = ys - dy;
      cell_d.z = d_i.z + ANG;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign q_o = cell_q;

endmodule

FILE: hw/rtl/cartesian_to_radar_measurement.sv
// ---------------------------------------------------------------------------
// Cartesian to radar measurement
// Converts position and velocity to range, bearing and range rate.
// ---------------------------------------------------------------------------
// The input stream carries one tracked state per item: pos_x, pos_y, vel_x
// and vel_y, each signed fixed point, packed from the lowest bit up. The
// output stream carries range, bearing and range rate in tdata and the
// near-zero flag in tuser. The configuration channel writes the near-zero
// limit and is always ready.
// One item is accepted per cycle unless stalled. Items pass the input, product
// and sum registers, 32 square root cells, the division setup register, 32
// division cells and the output register; the CORDIC chain runs alongside.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_tready_o falls in the same cycle; it rises again as soon as the
// result is taken. Reset empties the pipeline and sets the limit to one.
// ---------------------------------------------------------------------------
module cartesian_to_radar_measurement #(
  parameter int FRAC_BITS    = c2r_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = c2r_pkg::CORDIC_STEPS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_tvalid_i,
  output logic                        s_tready_o,
  // pos_x, pos_y, vel_x, vel_y
  input  logic [c2r_pkg::IN_W-1:0]    s_tdata_i,
  output logic                        m_tvalid_o,
  input  logic                        m_tready_i,
  // range, bearing, range_rate, zero padding
  output logic [c2r_pkg::OUT_W-1:0]   m_tdata_o,
  // near_zero
  output logic [0:0]                  m_tuser_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [c2r_pkg::LIMIT_W-1:0] cfg_data_i
);
  import c2r_pkg::*;

  localparam int LAT  = 2 + SQRT_STEPS + 1 + DIV_STEPS + 1;
  localparam int BDLY = LAT - 1 - (2 + NORM_STAGES + CORDIC_STEPS);
  localparam int RSH  = ANG_FRAC - FRAC_BITS;
  localparam logic signed [ZW-1:0] PI_S = $signed(PI_ANG);

  logic               en;
  logic [LAT:0]       vld_q;
  logic [LIMIT_W-1:0] limit_q;

  assign en          = !vld_q[LAT] || m_tready_i;
  assign s_tready_o  = en;
  assign m_tvalid_o  = vld_q[LAT];
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      limit_q <= LIMIT_W'(1);
    end else begin
      if (en) begin
        vld_q <= {vld_q[LAT-1:0], s_tvalid_i};
      end
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  logic signed [31:0] px_q;
  logic signed [31:0] py_q;
  logic signed [31:0] vx_q;
  logic signed [31:0] vy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q <= s_tdata_i[31:0];
      py_q <= s_tdata_i[63:32];
      vx_q <= s_tdata_i[95:64];
      vy_q <= s_tdata_i[127:96];
    end
  end

  // Range and dot product path.
  logic [31:0]        ax_abs;
  logic [31:0]        ay_abs;
  logic [63:0]        sqx_q;
  logic [63:0]        sqy_q;
  logic signed [63:0] p1_q;
  logic signed [63:0] p2_q;

  assign ax_abs = px_q[31] ? 32'(-px_q) : 32'(px_q);
  assign ay_abs = py_q[31] ? 32'(-py_q) : 32'(py_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx_q <= ax_abs * ax_abs;
      sqy_q <= ay_abs * ay_abs;
      p1_q  <= px_q * vx_q;
      p2_q  <= py_q * vy_q;
    end
  end

  logic [63:0] m1;
  logic [63:0] m2;
  logic [63:0] mag_d;
  logic        neg_d;
  logic [63:0] sumsq_q;
  logic [63:0] mag_q;
  logic        neg_q;

  always_comb begin
    m1 = p1_q[63] ? 64'(-p1_q) : 64'(p1_q);
    m2 = p2_q[63] ? 64'(-p2_q) : 64'(p2_q);
    if (p1_q[63] == p2_q[63]) begin
      mag_d = m1 + m2;
      neg_d = p1_q[63];
    end else if (m1 >= m2) begin
      mag_d = m1 - m2;
      neg_d = p1_q[63];
    end else begin
      mag_d = m2 - m1;
      neg_d = p2_q[63];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sumsq_q <= sqx_q + sqy_q;
      mag_q   <= mag_d;
      neg_q   <= neg_d;
    end
  end

  sqrt_t sq_c [SQRT_STEPS+1];

  assign sq_c[0] = '{v: sumsq_q, rem: '0, root: '0};

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    c2r_sqrt_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .d_i   (sq_c[g]),
      .q_o   (sq_c[g+1])
    );
  end

  logic [64:0] md_q [SQRT_STEPS];

  always_ff @(posedge clk_i) begin
    if (en) begin
      md_q[0] <= {neg_q, mag_q};
      for (int k = 1; k < SQRT_STEPS; k++) begin
        md_q[k] <= md_q[k-1];
      end
    end
  end

  logic [31:0] rng;
  logic [63:0] dmag;
  div_t        dv_d;
  div_t        dv_q;

  always_comb begin
    rng      = sq_c[SQRT_STEPS].root;
    dmag     = md_q[SQRT_STEPS-1][63:0];
    dv_d.rem = dmag;
    dv_d.quo = '0;
    dv_d.dvs = rng;
    dv_d.neg = md_q[SQRT_STEPS-1][64];
    dv_d.nz  = (rng < 32'(limit_q)) || (rng == 32'd0);
    dv_d.sat = dmag >= {rng, 32'd0};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_q <= dv_d;
    end
  end

  div_t dv_c [DIV_STEPS+1];

  assign dv_c[0] = dv_q;

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    c2r_div_cell #(
      .BIT (DIV_STEPS - 1 - g)
    ) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .d_i   (dv_c[g]),
      .q_o   (dv_c[g+1])
    );
  end

  // Bearing path.
  norm_t nm_d;
  norm_t nm_c [NORM_STAGES+1];

  always_comb begin
    nm_d.ax   = NORM_W'(ax_abs);
    nm_d.ay   = NORM_W'(ay_abs);
    nm_d.zero = (px_q == '0) && (py_q == '0);
    if (px_q[31]) begin
      nm_d.bsel = py_q[31] ? BASE_POS : BASE_NEG;
      nm_d.yneg = !py_q[31] && (py_q != '0);
      if (!py_q[31]) begin
        nm_d.bsel = BASE_POS;
      end else begin
        nm_d.bsel = BASE_NEG;
      end
    end else begin
      nm_d.bsel = BASE_NONE;
      nm_d.yneg = py_q[31];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nm_c[0] <= nm_d;
    end
  end

  for (genvar g = 0; g < NORM_STAGES; g++) begin : g_norm
    c2r_norm_cell #(
      .SHIFT (32 >> g)
    ) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .d_i   (nm_c[g]),
      .q_o   (nm_c[g+1])
    );
  end

  cord_t                cd_c [CORDIC_STEPS+1];
  logic signed [CW-1:0] ax_ext;
  logic signed [CW-1:0] ay_ext;

  assign ax_ext = $signed(CW'(nm_c[NORM_STAGES].ax));
  assign ay_ext = $signed(CW'(nm_c[NORM_STAGES].ay));

  always_comb begin
    cd_c[0].x    = ax_ext;
    cd_c[0].y    = nm_c[NORM_STAGES].yneg ? -ay_ext : ay_ext;
    cd_c[0].z    = '0;
    cd_c[0].bsel = nm_c[NORM_STAGES].bsel;
    cd_c[0].zero = nm_c[NORM_STAGES].zero;
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
    c2r_cordic_cell #(
      .STEP (g)
    ) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .d_i   (cd_c[g]),
      .q_o   (cd_c[g+1])
    );
  end

  logic signed [ZW-1:0] zbase;
  logic signed [ZW-1:0] zsum;
  logic [63:0]          zmag;
  logic [63:0]          zrnd;
  logic [63:0]          zres;
  logic [BEAR_W-1:0]    bear_d;
  logic [BEAR_W-1:0]    bear_q;

  always_comb begin
    case (cd_c[CORDIC_STEPS].bsel)
      BASE_POS: zbase = PI_S;
      BASE_NEG: zbase = -PI_S;
      default:  zbase = '0;
    endcase
    zsum = cd_c[CORDIC_STEPS].z + zbase;
    if (zsum > PI_S) begin
      zsum = PI_S;
    end
    if (zsum < -PI_S) begin
      zsum = -PI_S;
    end
    zmag = zsum[ZW-1] ? 64'(-zsum) : 64'(zsum);
    zrnd = (zmag + (64'd1 << (RSH - 1))) >> RSH;
    zres = zsum[ZW-1] ? -zrnd : zrnd;
    bear_d = cd_c[CORDIC_STEPS].zero ? '0 : zres[BEAR_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      bear_q <= bear_d;
    end
  end

  logic [BEAR_W-1:0] bd_q [BDLY];

  always_ff @(posedge clk_i) begin
    if (en) begin
      bd_q[0] <= bear_q;
      for (int k = 1; k < BDLY; k++) begin
        bd_q[k] <= bd_q[k-1];
      end
    end
  end

  // Output register.
  div_t              dv_o;
  logic [31:0]       rate_d;
  logic [31:0]       range_q;
  logic [BEAR_W-1:0] bear_o_q;
  logic [31:0]       rate_q;
  logic              nz_q;

  assign dv_o = dv_c[DIV_STEPS];

  always_comb begin
    if (dv_o.nz) begin
      rate_d = '0;
    end else if (dv_o.sat) begin
      rate_d = dv_o.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (dv_o.neg) begin
      rate_d = (dv_o.quo > 32'h8000_0000) ? 32'h8000_0000 : -dv_o.quo;
    end else begin
      rate_d = dv_o.quo[31] ? 32'h7FFF_FFFF : dv_o.quo;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      range_q  <= dv_o.dvs;
      bear_o_q <= bd_q[BDLY-1];
      rate_q   <= rate_d;
      nz_q     <= dv_o.nz;
    end
  end

  assign m_tdata_o = {5'd0, rate_q, bear_o_q, range_q};
  assign m_tuser_o = nz_q;

endmodule

FILE: hw/rtl/c2r_checker.sv
// ---------------------------------------------------------------------------
// Cartesian to radar measurement checker
// Port-level assertions, bound to the top level.
// ---------------------------------------------------------------------------
`include "cartesian_to_radar_measurement_macros.svh"

module c2r_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_tvalid_i,
  input logic                        s_tready_o,
  input logic [c2r_pkg::IN_W-1:0]    s_tdata_i,
  input logic                        m_tvalid_o,
  input logic                        m_tready_i,
  input logic [c2r_pkg::OUT_W-1:0]   m_tdata_o,
  input logic [0:0]                  m_tuser_o,
  input logic                        cfg_valid_i,
  input logic                        cfg_ready_o,
  input logic [c2r_pkg::LIMIT_W-1:0] cfg_data_i
);

  `C2R_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_tvalid_o && !m_tready_i, m_tvalid_o && $stable(m_tdata_o), "stalled item changed")
  `C2R_ASSERT_IMPL(a_ready, clk_i, rst_ni, !s_tready_o, m_tvalid_o && !m_tready_i, "input stalled without cause")
  `C2R_ASSERT_IMPL(a_nz_rate, clk_i, rst_ni, m_tvalid_o && m_tuser_o[0], m_tdata_o[82:51] == 32'd0, "near zero with rate")
  `C2R_ASSERT_IMPL(a_zero_flag, clk_i, rst_ni, m_tvalid_o && (m_tdata_o[31:0] == 32'd0), m_tuser_o[0], "zero range not flagged")
  `C2R_ASSERT_IMPL(a_zero_bear, clk_i, rst_ni, m_tvalid_o && (m_tdata_o[31:0] == 32'd0), m_tdata_o[50:32] == 19'd0, "zero range with bearing")

endmodule

bind cartesian_to_radar_measurement c2r_checker u_c2r_checker (.*);
